### hw/rtl/linear_probe_key_map_top_macros.svh
// assertion macros for the linear probe key map
// expects clk and arst_n in the scope of the module that uses them
`ifndef LINEAR_PROBE_KEY_MAP_TOP_MACROS_SVH
`define LINEAR_PROBE_KEY_MAP_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define LPKM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define LPKM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lpkm_pkg.sv
// shared types and constants of the linear probe key map
// no dependencies
package lpkm_pkg;

	localparam int unsigned KEY_W           = 64;
	localparam int unsigned KIND_W          = 2;
	localparam int unsigned STATUS_W        = 3;
	localparam int unsigned SLOT_W          = 10;
	localparam int unsigned HASH_SHIFT      = 3;
	localparam int unsigned TABLE_SLOTS_DEF = 1024;
	localparam int unsigned QUEUE_DEPTH     = 2;
	// key bits folded into the remainder per cycle by the serial hash
	localparam int unsigned HASH_DIGITS     = 8;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 3'd0,
		ST_INSERTED = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_MISS     = 3'd3,
		ST_INVALID  = 3'd4
	} status_t;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_LOOKUP  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_INVALID = 3'd3,
		OP_MISS    = 3'd4
	} op_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} work_t;

endpackage

### hw/rtl/lpkm_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module lpkm_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/lpkm_front.sv
// front part: accepts requests, classifies them and computes the home slot
// depends on lpkm_pkg
module lpkm_front #(
	parameter int unsigned TABLE_SLOTS = lpkm_pkg::TABLE_SLOTS_DEF,
	localparam int unsigned HW = $clog2(TABLE_SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hold,
	input  logic                req_valid,
	output logic                req_ready,
	input  lpkm_pkg::req_t      req,
	output logic                push_valid,
	input  logic                push_ready,
	output lpkm_pkg::work_t     push_work,
	output logic [HW-1:0]       push_home
);

	localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

	logic            full_q;
	lpkm_pkg::work_t work_q;
	logic            hash_done;
	logic [HW-1:0]   home;
	logic            accept;
	lpkm_pkg::op_t   op_cls;

	assign push_valid = full_q && hash_done;
	assign req_ready  = !hold && (!full_q || (push_valid && push_ready));
	assign accept     = req_valid && req_ready;
	assign push_work  = work_q;
	assign push_home  = home;

	// classification
	always_comb begin
		if (req.key == '0) begin
			op_cls = lpkm_pkg::OP_INVALID;
		end else begin
			unique case (req.kind)
				lpkm_pkg::KIND_LOOKUP: op_cls = lpkm_pkg::OP_LOOKUP;
				lpkm_pkg::KIND_INSERT: op_cls = lpkm_pkg::OP_INSERT;
				lpkm_pkg::KIND_REMOVE: op_cls = lpkm_pkg::OP_REMOVE;
				default:               op_cls = lpkm_pkg::OP_MISS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (accept) begin
			full_q <= 1'b1;
		end else if (push_valid && push_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_q.op  <= op_cls;
			work_q.key <= req.key;
		end
	end

	generate
		if (POW2) begin : g_mask
			// home slot is a plain bit field of the key
			logic [HW-1:0] home_q;

			always_ff @(posedge clk) begin
				if (accept) begin
					home_q <= req.key[lpkm_pkg::HASH_SHIFT +: HW];
				end
			end

			assign hash_done = 1'b1;
			assign home      = home_q;
		end else begin : g_serial
			// restoring remainder, msb first, HASH_DIGITS key bits per cycle
			localparam int unsigned STEPS  = lpkm_pkg::KEY_W / lpkm_pkg::HASH_DIGITS;
			localparam int unsigned SW     = $clog2(STEPS);
			localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);
			localparam logic [HW:0] NMOD   = (HW + 1)'(TABLE_SLOTS);

			logic                      run_q;
			logic [SW-1:0]             step_q;
			logic [lpkm_pkg::KEY_W-1:0] sh_q;
			logic [HW-1:0]             rem_q;
			logic [HW-1:0]             rem_nxt;

			always_comb begin : rem_calc
				logic [HW:0]   t;
				logic [HW-1:0] r;
				r = rem_q;
				t = '0;
				for (int j = 0; j < int'(lpkm_pkg::HASH_DIGITS); j++) begin
					t = {r, sh_q[lpkm_pkg::KEY_W - 1 - j]};
					if (t >= NMOD) begin
						t = t - NMOD;
					end
					r = t[HW-1:0];
				end
				rem_nxt = r;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q  <= 1'b0;
					step_q <= '0;
				end else if (accept) begin
					run_q  <= 1'b1;
					step_q <= '0;
				end else if (run_q) begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						run_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (accept) begin
					sh_q  <= req.key >> lpkm_pkg::HASH_SHIFT;
					rem_q <= '0;
				end else if (run_q) begin
					sh_q  <= sh_q << lpkm_pkg::HASH_DIGITS;
					rem_q <= rem_nxt;
				end
			end

			assign hash_done = !run_q;
			assign home      = rem_q;
		end
	endgenerate

endmodule

### hw/rtl/lpkm_queue.sv
// short fifo between front and back
// no dependencies
module lpkm_queue #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 2,
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL  = CW'(DEPTH);

	logic [DATA_W-1:0] ent_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != FULL;
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = ent_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/lpkm_back.sv
// back part: clears the table, probes one slot per cycle, holds the result
// depends on lpkm_pkg and lpkm_ram
module lpkm_back #(
	parameter int unsigned TABLE_SLOTS = lpkm_pkg::TABLE_SLOTS_DEF,
	localparam int unsigned HW = $clog2(TABLE_SLOTS)
) (
	input  logic            clk,
	input  logic            arst_n,
	output logic            clearing,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  lpkm_pkg::work_t pop_work,
	input  logic [HW-1:0]   pop_home,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output lpkm_pkg::rsp_t  rsp
);

	localparam logic [HW-1:0] LAST = HW'(TABLE_SLOTS - 1);
	localparam int unsigned SW = lpkm_pkg::SLOT_W;

	typedef enum logic [3:0] {
		BK_CLEAR = 4'b0001,
		BK_IDLE  = 4'b0010,
		BK_PROBE = 4'b0100,
		BK_HOLD  = 4'b1000
	} bk_state_t;

	bk_state_t                   state_q;
	logic [HW-1:0]               clr_q;
	logic [HW-1:0]               cnt_q;
	logic [HW-1:0]               nxt_q;
	logic [HW-1:0]               chk_idx_s1;
	lpkm_pkg::work_t             work_q;
	lpkm_pkg::rsp_t              res_q;
	logic                        rsp_valid_q;
	lpkm_pkg::rsp_t              rsp_q;

	logic                        we;
	logic [HW-1:0]               waddr;
	logic [lpkm_pkg::KEY_W-1:0]  wdata;
	logic [HW-1:0]               raddr;
	logic [lpkm_pkg::KEY_W-1:0]  rdata;

	logic                        fin_valid;
	lpkm_pkg::rsp_t              fin_rsp;
	logic                        rsp_free;
	logic                        pop_reject;
	logic                        hit_match;
	logic                        hit_empty;
	logic [SW+HW-1:0]            slot_wide;

	lpkm_ram #(
		.WIDTH(lpkm_pkg::KEY_W),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign clearing   = state_q == BK_CLEAR;
	assign pop_ready  = state_q == BK_IDLE;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign rsp_free   = !rsp_valid_q || rsp_ready;
	assign pop_reject = pop_work.op == lpkm_pkg::OP_INVALID || pop_work.op == lpkm_pkg::OP_MISS;
	// stored keys are never zero, so a zero word marks a free slot
	assign hit_match  = rdata == work_q.key && work_q.op != lpkm_pkg::OP_INVALID;
	assign hit_empty  = rdata == '0 && work_q.op == lpkm_pkg::OP_INSERT;
	assign slot_wide  = {{SW{1'b0}}, chk_idx_s1};

	always_comb begin
		fin_valid      = 1'b0;
		fin_rsp.status = lpkm_pkg::ST_MISS;
		fin_rsp.slot   = '0;
		we             = 1'b0;
		waddr          = chk_idx_s1;
		wdata          = '0;
		raddr          = nxt_q;
		unique case (state_q)
			BK_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			BK_IDLE: begin
				raddr = pop_home;
				if (pop_valid && pop_reject) begin
					fin_valid = 1'b1;
					if (pop_work.op == lpkm_pkg::OP_INVALID) begin
						fin_rsp.status = lpkm_pkg::ST_INVALID;
					end
				end
			end
			BK_PROBE: begin
				if (hit_match) begin
					fin_valid    = 1'b1;
					fin_rsp.slot = slot_wide[SW-1:0];
					if (work_q.op == lpkm_pkg::OP_REMOVE) begin
						fin_rsp.status = lpkm_pkg::ST_REMOVED;
						we             = 1'b1;
					end else begin
						fin_rsp.status = lpkm_pkg::ST_FOUND;
					end
				end else if (hit_empty) begin
					fin_valid      = 1'b1;
					fin_rsp.status = lpkm_pkg::ST_INSERTED;
					fin_rsp.slot   = slot_wide[SW-1:0];
					we             = 1'b1;
					wdata          = work_q.key;
				end else if (cnt_q == LAST) begin
					fin_valid = 1'b1;
				end
			end
			BK_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin_valid && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (state_q == BK_HOLD && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						state_q <= BK_IDLE;
					end
				end
				BK_IDLE: begin
					if (pop_valid && !pop_reject) begin
						state_q <= BK_PROBE;
					end else if (fin_valid && !rsp_free) begin
						state_q <= BK_HOLD;
					end
				end
				BK_PROBE: begin
					if (fin_valid) begin
						state_q <= rsp_free ? BK_IDLE : BK_HOLD;
					end
				end
				BK_HOLD: begin
					if (rsp_free) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_CLEAR;
			endcase
		end
	end

	// probe datapath
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && pop_valid) begin
			work_q     <= pop_work;
			chk_idx_s1 <= pop_home;
			nxt_q      <= (pop_home == LAST) ? '0 : pop_home + 1'b1;
			cnt_q      <= '0;
		end else if (state_q == BK_PROBE && !fin_valid) begin
			chk_idx_s1 <= nxt_q;
			nxt_q      <= (nxt_q == LAST) ? '0 : nxt_q + 1'b1;
			cnt_q      <= cnt_q + 1'b1;
		end
		if (fin_valid && !rsp_free) begin
			res_q <= fin_rsp;
		end
		if (fin_valid && rsp_free) begin
			rsp_q <= fin_rsp;
		end else if (state_q == BK_HOLD && rsp_free) begin
			rsp_q <= res_q;
		end
	end

endmodule

### hw/rtl/linear_probe_key_map_top.sv
// linear probe key map, top level: front, queue and back wired together
// depends on lpkm_pkg, lpkm_front, lpkm_queue, lpkm_back and the macro header
//
// usage
// - request channel req_valid/req_ready/req carries {kind, key}; kind lookup,
//   lookup-or-insert or remove; a zero key answers invalid and changes nothing
// - response channel rsp_valid/rsp_ready/rsp carries {status, slot}, exactly
//   one response per request, in request order
// - after reset the back sweeps the slot memory clearing one slot per cycle;
//   req_ready stays low until the sweep is done
// - the front registers a request, computing the home slot serially when
//   TABLE_SLOTS is not a power of two; the back reads the home slot, probes
//   further slots as needed and registers the response; a rejected request
//   (zero key, unused kind) is answered from the idle state without a probe
// - the back takes no new request until the last one is finished and probes
//   one slot per cycle through the single read port of the slot memory; a
//   miss on a full table probes all TABLE_SLOTS slots
// - the front keeps accepting into a two-entry queue while the back works, and
//   the back keeps probing while a finished response waits in the output
//   register; a stalled receiver only stops the back once it has a second result
`include "linear_probe_key_map_top_macros.svh"

module linear_probe_key_map_top #(
	parameter int unsigned TABLE_SLOTS = lpkm_pkg::TABLE_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lpkm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lpkm_pkg::rsp_t rsp
);

	localparam int unsigned HW = $clog2(TABLE_SLOTS);
	localparam int unsigned QW = $bits(lpkm_pkg::work_t) + HW;

	// front to queue
	logic            push_valid;
	logic            push_ready;
	lpkm_pkg::work_t push_work;
	logic [HW-1:0]   push_home;

	// queue to back
	logic            pop_valid;
	logic            pop_ready;
	logic [QW-1:0]   pop_data;
	lpkm_pkg::work_t pop_work;
	logic [HW-1:0]   pop_home;

	// high during the post-reset table sweep
	logic            clearing;

	// request transaction taken this cycle
	logic            req_take;
	// response carries a miss or an invalid-key answer
	logic            rsp_no_slot;

	lpkm_front #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (clearing),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_work (push_work),
		.push_home (push_home)
	);

	lpkm_queue #(
		.DATA_W(QW),
		.DEPTH (lpkm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_work, push_home}),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// unpack the queue word
	assign pop_work = lpkm_pkg::work_t'(pop_data[QW-1:HW]);
	assign pop_home = pop_data[HW-1:0];

	lpkm_back #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_work (pop_work),
		.pop_home (pop_home),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	assign req_take    = req_valid && req_ready;
	assign rsp_no_slot = rsp.status == lpkm_pkg::ST_MISS || rsp.status == lpkm_pkg::ST_INVALID;

	// no transaction may enter while the table is being swept
	`LPKM_ASSERT_IMP(a_no_accept_in_clear, req_take, !clearing, "request taken during sweep")

	// misses and invalid keys always report slot zero
	`LPKM_ASSERT_IMP(a_miss_slot_zero, rsp_valid && rsp_no_slot, rsp.slot == '0, "nonzero slot")

	// nothing can be answered during or right after the sweep
	`LPKM_ASSERT_NXT(a_no_rsp_after_clear, clearing, !rsp_valid, "response during sweep")

endmodule
